// ===== rtl/mcr_pkg.sv =====
`timescale 1ns / 1ps

package mcr_pkg;

    localparam int SURFACE_SIZE_DEF = 256;
    localparam logic [31:0] PIXEL_COLOR_RST = 32'h00FF00FF;

    localparam int RADIUS_W = 7;
    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 32;
    localparam int X_W      = 9;
    localparam int Y_W      = 8;
    localparam int ERR_W    = 12;
    localparam int DX_W     = 11;
    localparam int DY_W     = 10;
    localparam int PIX_PER_STEP = 8;
    localparam int PIX_IDX_W    = $clog2(PIX_PER_STEP);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } mcr_cmd_t;

    // One octant point to be mirrored into eight pixel writes.
    typedef struct packed {
        logic [RADIUS_W-1:0] x;
        logic [RADIUS_W-1:0] y;
        logic                done;
    } mcr_job_t;

    typedef struct packed {
        logic     push;
        mcr_job_t job;
    } mcr_push_t;

    typedef struct packed {
        logic     valid;
        mcr_job_t job;
    } mcr_head_t;

endpackage

// ===== rtl/mcr_front.sv =====
`timescale 1ns / 1ps

module mcr_front
    import mcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic                in_cmd,
    input  logic [RADIUS_W-1:0] in_radius,
    output mcr_push_t           push_out
);

    logic signed [X_W-1:0]   x_reg,   x_next;
    logic        [Y_W-1:0]   y_reg,   y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [DX_W-1:0]  dx_reg,  dx_next;
    logic signed [DY_W-1:0]  dy_reg,  dy_next;
    logic                    active_reg, active_next;

    logic signed [ERR_W-1:0] err_step;
    logic                    is_step;
    logic                    done;

    assign is_step = (in_cmd == CMD_STEP);

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        active_next = active_reg;
        err_step    = err_reg + ERR_W'(dy_reg);
        done        = 1'b0;

        push_out.push   = 1'b0;
        push_out.job.x  = x_reg[RADIUS_W-1:0];
        push_out.job.y  = y_reg[RADIUS_W-1:0];
        push_out.job.done = 1'b0;

        if (in_accept && !is_step) begin
            x_next      = X_W'(in_radius);
            y_next      = '0;
            err_next    = ERR_W'({in_radius, 1'b0}) - ERR_W'(1);
            dx_next     = DX_W'({in_radius, 2'b00}) - DX_W'(4);
            dy_next     = -DY_W'(2);
            active_next = 1'b1;
        end else if (in_accept && active_reg) begin
            y_next   = y_reg + Y_W'(1);
            dy_next  = dy_reg - DY_W'(4);
            err_next = err_step;
            if (err_step < 0) begin
                err_next = err_step + ERR_W'(dx_reg);
                dx_next  = dx_reg - DX_W'(4);
                x_next   = x_reg - X_W'(1);
            end
            done = $signed({1'b0, y_next}) > x_next;
            if (done) begin
                active_next = 1'b0;
            end
            push_out.push     = 1'b1;
            push_out.job.done = done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            err_reg    <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            active_reg <= 1'b0;
        end else begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            err_reg    <= err_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/mcr_queue.sv =====
`timescale 1ns / 1ps

module mcr_queue
    import mcr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mcr_push_t push_in,
    input  logic      pop,
    output mcr_head_t head,
    output logic      full
);

    mcr_job_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_pop;

    assign do_pop     = pop && (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_in.push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push_in.push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push_in.push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem[wr_ptr_reg] <= push_in.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/mcr_back.sv =====
`timescale 1ns / 1ps

module mcr_back
    import mcr_pkg::*;
#(
    parameter int SURFACE_SIZE = SURFACE_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mcr_head_t           head,
    output logic                pop,
    input  logic [COLOR_W-1:0]  pixel_color,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  out_row,
    output logic [COORD_W-1:0]  out_column,
    output logic [COLOR_W-1:0]  out_color,
    output logic                out_last,
    output logic                out_done
);

    localparam int OFS_W   = RADIUS_W + 1;
    localparam int LUT_LEN = 2 ** OFS_W;

    // Wrapped surface coordinate for each signed offset from the centre.
    logic [COORD_W-1:0] wrap_lut [LUT_LEN];

    for (genvar i = 0; i < LUT_LEN; i++) begin : g_wrap
        localparam int Ofs = (i < LUT_LEN / 2) ? i : i - LUT_LEN;
        localparam int Wrapped =
            (((SURFACE_SIZE / 2) + Ofs) % SURFACE_SIZE + SURFACE_SIZE) % SURFACE_SIZE;
        assign wrap_lut[i] = COORD_W'(Wrapped);
    end

    mcr_job_t             job_reg,       job_next;
    logic                 job_valid_reg, job_valid_next;
    logic [PIX_IDX_W-1:0] idx_reg,       idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   row_reg,       row_next;
    logic [COORD_W-1:0]   column_reg,    column_next;
    logic [COLOR_W-1:0]   color_reg,     color_next;
    logic                 last_reg,      last_next;
    logic                 done_reg,      done_next;

    logic                 advance;
    logic                 final_pix;
    logic [RADIUS_W-1:0]  row_mag, col_mag;
    logic [OFS_W-1:0]     row_ofs, col_ofs;

    assign advance   = job_valid_reg && (!out_valid_reg || out_ready);
    assign final_pix = (idx_reg == PIX_IDX_W'(PIX_PER_STEP - 1));
    assign pop       = head.valid && (!job_valid_reg || (advance && final_pix));

    // The upper index bit swaps the roles of X and Y; the lower two bits pick the signs.
    assign row_mag = idx_reg[2] ? job_reg.x : job_reg.y;
    assign col_mag = idx_reg[2] ? job_reg.y : job_reg.x;
    assign row_ofs = idx_reg[1] ? {1'b0, row_mag} : -{1'b0, row_mag};
    assign col_ofs = idx_reg[0] ? {1'b0, col_mag} : -{1'b0, col_mag};

    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        row_next       = row_reg;
        column_next    = column_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = 1'b1;
            row_next       = wrap_lut[row_ofs];
            column_next    = wrap_lut[col_ofs];
            color_next     = pixel_color;
            last_next      = final_pix;
            done_next      = final_pix && job_reg.done;
            idx_next       = idx_reg + PIX_IDX_W'(1);
            if (final_pix) begin
                job_valid_next = 1'b0;
            end
        end

        if (pop) begin
            job_next       = head.job;
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        row_reg    <= row_next;
        column_reg <= column_next;
        color_reg  <= color_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = row_reg;
    assign out_column = column_reg;
    assign out_color  = color_reg;
    assign out_last   = last_reg;
    assign out_done   = done_reg;

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// s_        in         tdata: radius[6:0], zero pad;  tuser: command
// m_        out        tdata: row[7:0], column[15:8], colour[47:16];
//                      tlast: last of step;  tuser: circle done
// cfg_      in         cfg_wdata: pixel colour, written when cfg_we is high
//
// A start word produces no output. A step word taken while a circle is active yields
// eight output words, one per cycle while m_tready is high, from the pixel sequencer
// of the back end.
// A two-entry job queue sits between the front and back ends; input stalls only when
// it is full. A low m_tready holds the output word. Reset is synchronous and clears
// all control state; the colour register returns to 0x00FF00FF.

module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int SURFACE_SIZE = SURFACE_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // radius[6:0], zero pad
    input  logic [0:0]         s_tuser,   // command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // row, column, pixel_color_res
    output logic               m_tlast,
    output logic [0:0]         m_tuser,   // circle_done
    input  logic               cfg_we,
    input  logic [COLOR_W-1:0] cfg_wdata
);

    logic [COLOR_W-1:0] pixel_color_reg;
    logic               in_accept;
    logic               queue_full;
    logic               pop;
    mcr_push_t          push;
    mcr_head_t          head;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [COLOR_W-1:0] color;

    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_color_reg <= PIXEL_COLOR_RST;
        end else if (cfg_we) begin
            pixel_color_reg <= cfg_wdata;
        end
    end

    mcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_tuser[0]),
        .in_radius (s_tdata[RADIUS_W-1:0]),
        .push_out  (push)
    );

    mcr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    mcr_back #(
        .SURFACE_SIZE (SURFACE_SIZE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .pop         (pop),
        .pixel_color (pixel_color_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_row     (row),
        .out_column  (column),
        .out_color   (color),
        .out_last    (m_tlast),
        .out_done    (m_tuser[0])
    );

    assign m_tdata = {color, column, row};

endmodule
